>>> design/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared widths, codes and controller/datapath types for the palette color
// cycler.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int COLOR_W    = 16;
  localparam int PAL_W      = 6;
  localparam int SLOT_W     = 4;
  localparam int ELAPSED_W  = 8;
  localparam int COUNT_W    = 5;
  localparam int DELAY_W    = 16;
  localparam int CD_W       = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START   = 2'd0,
    REG_COUNT   = 2'd1,
    REG_REVERSE = 2'd2,
    REG_DELAY   = 2'd3
  } pcc_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_EMIT
  } pcc_state_t;

  typedef struct packed {
    logic load;    // write one ring slot
    logic sub;     // countdown minus elapsed
    logic fire;    // reload countdown, restart position
    logic rotate;  // shift the active ring by one entry
    logic emit;    // load the output register with the next color
  } pcc_cmd_t;

  typedef struct packed {
    logic expired;   // countdown at or below zero
    logic k_last;    // current position is the final one of the run
    logic out_free;  // output register can take a new item
  } pcc_status_t;

endpackage

>>> design/pcc_in_if.sv
// ----------------------------------------------------------------------------
// pcc_in_if
// Input channel: load and tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcc_in_if import pcc_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [SLOT_W-1:0]    slot;
  logic [COLOR_W-1:0]   color_word;
  logic [ELAPSED_W-1:0] elapsed;

  modport source(output valid, action, slot, color_word, elapsed, input ready);
  modport sink(input valid, action, slot, color_word, elapsed, output ready);
endinterface

>>> design/pcc_out_if.sv
// ----------------------------------------------------------------------------
// pcc_out_if
// Result channel: palette writes with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcc_out_if import pcc_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [PAL_W-1:0]   palette_index;
  logic [COLOR_W-1:0] color_out;
  logic               last;

  modport source(output valid, palette_index, color_out, last, input ready);
  modport sink(input valid, palette_index, color_out, last, output ready);
endinterface

>>> design/pcc_cfg_if.sv
// ----------------------------------------------------------------------------
// pcc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pcc_cfg_if import pcc_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> design/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl
// Controller: takes items, decides load / countdown / fire, sequences the
// rotate step and the emit run.
// ----------------------------------------------------------------------------
module pcc_ctrl import pcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_action,
  output logic        in_ready,
  input  pcc_status_t status,
  output pcc_cmd_t    cmd
);

  pcc_state_t state_r;
  pcc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_TICK && status.expired) begin
          state_nxt = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.k_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_LOAD) begin
            cmd.load = 1'b1;
          end else if (!status.expired) begin
            cmd.sub = 1'b1;
          end else begin
            cmd.fire = 1'b1;
          end
        end
      end
      ST_ROTATE: begin
        cmd.rotate = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> design/pcc_dpath.sv
// ----------------------------------------------------------------------------
// pcc_dpath
// Datapath: configuration registers, color ring, countdown, run position
// and the output register.
// ----------------------------------------------------------------------------
module pcc_dpath import pcc_pkg::*; #(
  parameter int MAX_COLORS = 16,
  parameter int RING_CAP   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcc_cmd_t              cmd,
  output pcc_status_t           status,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [COLOR_W-1:0]    in_color_word,
  input  logic [ELAPSED_W-1:0]  in_elapsed,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [PAL_W-1:0]      out_palette_index,
  output logic [COLOR_W-1:0]    out_color_out,
  output logic                  out_last
);

  localparam int IW = $clog2(RING_CAP);

  logic [PAL_W-1:0]   start_r;
  logic [COUNT_W-1:0] count_r;
  logic               reverse_r;
  logic [DELAY_W-1:0] delay_r;

  logic [COLOR_W-1:0] ring_r   [RING_CAP];
  logic [COLOR_W-1:0] ring_nxt [RING_CAP];
  logic [COLOR_W-1:0] prev_c   [RING_CAP];
  logic [COLOR_W-1:0] next_c   [RING_CAP];

  logic [CD_W-1:0]    cd_r;
  logic [CD_W-1:0]    cd_nxt;
  logic [IW-1:0]      k_r;
  logic [IW-1:0]      k_nxt;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [PAL_W-1:0]   out_idx_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;

  logic [COUNT_W-1:0] n_act;
  logic [COUNT_W-1:0] n_m1;
  logic [IW-1:0]      rd_addr;
  logic [COLOR_W-1:0] rd_data;
  logic               slot_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      count_r   <= COUNT_W'(1);
      reverse_r <= 1'b0;
      delay_r   <= '0;
    end else if (cfg_valid) begin
      unique case (pcc_reg_t'(cfg_index))
        REG_START:   start_r   <= cfg_data[PAL_W-1:0];
        REG_COUNT:   count_r   <= cfg_data[COUNT_W-1:0];
        REG_REVERSE: reverse_r <= cfg_data[0];
        REG_DELAY:   delay_r   <= cfg_data[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // active run length, zero counts as one, saturated to the ring size
  always_comb begin
    if (count_r == '0) begin
      n_act = COUNT_W'(1);
    end else if (count_r > COUNT_W'(RING_CAP)) begin
      n_act = COUNT_W'(RING_CAP);
    end else begin
      n_act = count_r;
    end
  end

  assign n_m1 = n_act - COUNT_W'(1);

  // single read port: wrap-around entry during rotate, run position otherwise
  always_comb begin
    if (cmd.rotate) begin
      rd_addr = reverse_r ? '0 : n_m1[IW-1:0];
    end else begin
      rd_addr = k_r;
    end
  end

  assign rd_data = ring_r[rd_addr];

  for (genvar i = 0; i < RING_CAP; i++) begin : g_nb
    if (i == 0) begin : g_first
      assign prev_c[i] = rd_data;
    end else begin : g_prev
      assign prev_c[i] = ring_r[i-1];
    end
    if (i == RING_CAP - 1) begin : g_end
      assign next_c[i] = rd_data;
    end else begin : g_next
      assign next_c[i] = ring_r[i+1];
    end
  end

  assign slot_ok = (32'(in_slot) < MAX_COLORS);

  always_comb begin
    for (int i = 0; i < RING_CAP; i++) begin
      ring_nxt[i] = ring_r[i];
      if (cmd.rotate) begin
        if (!reverse_r) begin
          if (COUNT_W'(i) < n_act) begin
            ring_nxt[i] = prev_c[i];
          end
        end else begin
          if (COUNT_W'(i) == n_m1) begin
            ring_nxt[i] = rd_data;
          end else if (COUNT_W'(i) < n_m1) begin
            ring_nxt[i] = next_c[i];
          end
        end
      end
    end
    if (cmd.load && slot_ok) begin
      ring_nxt[in_slot[IW-1:0]] = in_color_word;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RING_CAP; i++) begin
      ring_r[i] <= ring_nxt[i];
    end
  end

  // countdown and run position
  always_comb begin
    cd_nxt = cd_r;
    k_nxt  = k_r;
    if (cmd.sub) begin
      cd_nxt = cd_r - CD_W'(in_elapsed);
    end
    if (cmd.fire) begin
      cd_nxt = CD_W'(delay_r);
      k_nxt  = '0;
    end
    if (cmd.emit) begin
      k_nxt = k_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r <= '0;
      k_r  <= '0;
    end else begin
      cd_r <= cd_nxt;
      k_r  <= k_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r   <= start_r + PAL_W'(k_r);
      out_color_r <= rd_data;
      out_last_r  <= status.k_last;
    end
  end

  assign status.expired  = cd_r[CD_W-1] || (cd_r == '0);
  assign status.k_last   = (COUNT_W'(k_r) == n_m1);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_palette_index = out_idx_r;
  assign out_color_out     = out_color_r;
  assign out_last          = out_last_r;

endmodule

>>> design/palette_color_cycler.sv
// ----------------------------------------------------------------------------
// palette_color_cycler
// Rotates a ring of color words on expired ticks and writes the cycled
// range out as a run of palette entries.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : load items (action 0) write color_word into ring slot; a slot
//            at or above MAX_COLORS is dropped. Tick items (action 1)
//            subtract elapsed from the countdown while it is positive.
//   out_ch : on a tick that finds the countdown at or below zero, the
//            active range is rotated by one and n colors come out, one per
//            cycle unless stalled, palette_index = start_color + position
//            mod 64, last on the final one; the countdown reloads from delay.
//   cfg_ch : always ready; register index per pcc_reg_t, write only idle.
// Timing
//   loads and non-firing ticks are taken back to back.
//   a firing tick holds off the next item while it is accepted, the
//   active range is rotated (the ring's single read port fetches the
//   wrap-around entry) and the run is emitted, one per cycle through the
//   output register. A stalled receiver holds the run in place.
// Reset: rst_n low clears the countdown, the controller and the config
//   registers (count 1, others 0); ring contents are undefined until loaded.
// ----------------------------------------------------------------------------
module palette_color_cycler import pcc_pkg::*; #(
  parameter int MAX_COLORS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pcc_in_if.sink    in_ch,
  pcc_out_if.source out_ch,
  pcc_cfg_if.sink   cfg_ch
);

  localparam int RING_CAP = (MAX_COLORS > 16) ? 16 : MAX_COLORS;

  pcc_cmd_t    cmd;
  pcc_status_t status;

  assign cfg_ch.ready = 1'b1;

  pcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pcc_dpath #(
    .MAX_COLORS (MAX_COLORS),
    .RING_CAP   (RING_CAP)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_slot           (in_ch.slot),
    .in_color_word     (in_ch.color_word),
    .in_elapsed        (in_ch.elapsed),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_palette_index (out_ch.palette_index),
    .out_color_out     (out_ch.color_out),
    .out_last          (out_ch.last)
  );

endmodule

>>> design/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks on the palette color cycler, bound to the top level.
// ----------------------------------------------------------------------------
module pcc_checker import pcc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_action,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PAL_W-1:0]   out_palette_index,
  input logic [COLOR_W-1:0] out_color_out,
  input logic               out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_palette_index) && $stable(out_color_out) && $stable(out_last))
    else $error("result payload changed while stalled");

  // new items only once the run is complete
  a_idle_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_last))
    else $error("input taken in the middle of a run");

  // a load item never blocks the next one
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_LOAD |=> in_ready)
    else $error("load item stalled the input");

endmodule

bind palette_color_cycler pcc_checker u_pcc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_action         (in_ch.action),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_palette_index (out_ch.palette_index),
  .out_color_out     (out_ch.color_out),
  .out_last          (out_ch.last)
);

>>> tb/sv/palette_write_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_write_checker
// Watches the input, configuration and palette write channels of the color
// cycler, keeps its own copy of the ring, countdown and registers, predicts
// every palette write and compares each accepted write field by field.
// ----------------------------------------------------------------------------
module palette_write_checker import pcc_pkg::*; #(
  parameter int MAX_COLORS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pcc_in_if           in_ch,
  pcc_out_if          out_ch,
  pcc_cfg_if          cfg_ch,
  output int unsigned fail_count,
  output int unsigned writes_due
);

  localparam int RING_CAP = (MAX_COLORS > 16) ? 16 : MAX_COLORS;

  typedef struct packed {
    logic [PAL_W-1:0]   index;
    logic [COLOR_W-1:0] color;
    logic               last;
  } palette_write_t;

  logic [COLOR_W-1:0]   ring_q [MAX_COLORS];
  logic signed [CD_W-1:0] countdown_q;
  logic [PAL_W-1:0]     start_q;
  logic [COUNT_W-1:0]   count_q;
  logic                 reverse_q;
  logic [DELAY_W-1:0]   delay_q;

  palette_write_t palette_writes_due[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("checker: %s got %0h want %0h at %0t", what, got, want, $time);
    end
  endtask

  function automatic int cycled_length();
    int n;
    n = count_q;
    if (n == 0) n = 1;
    if (n > RING_CAP) n = RING_CAP;
    return n;
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    case (pcc_reg_t'(idx))
      REG_START:   start_q = value[PAL_W-1:0];
      REG_COUNT:   count_q = value[COUNT_W-1:0];
      REG_REVERSE: reverse_q = value[0];
      REG_DELAY:   delay_q = value[DELAY_W-1:0];
      default: ;
    endcase
  endtask

  // one input item: load a slot, count down, or rotate and queue the run
  task automatic advance_palette(input logic act, input logic [SLOT_W-1:0] slot,
                                 input logic [COLOR_W-1:0] word,
                                 input logic [ELAPSED_W-1:0] elapsed);
    int n;
    logic [COLOR_W-1:0] keep;
    palette_write_t pw;
    if (act == ACT_LOAD) begin
      if (slot < MAX_COLORS) ring_q[slot] = word;
    end else if (countdown_q > 0) begin
      countdown_q = countdown_q - $signed({{(CD_W-ELAPSED_W){1'b0}}, elapsed});
    end else begin
      n = cycled_length();
      if (n >= 2) begin
        if (reverse_q) begin
          keep = ring_q[0];
          for (int i = 0; i < n - 1; i++) ring_q[i] = ring_q[i+1];
          ring_q[n-1] = keep;
        end else begin
          keep = ring_q[n-1];
          for (int i = n - 1; i > 0; i--) ring_q[i] = ring_q[i-1];
          ring_q[0] = keep;
        end
      end
      for (int k = 0; k < n; k++) begin
        pw.index = PAL_W'(start_q + k);
        pw.color = ring_q[k];
        pw.last  = (k == n - 1);
        palette_writes_due.push_back(pw);
      end
      countdown_q = $signed({{(CD_W-DELAY_W){1'b0}}, delay_q});
    end
  endtask

  always @(posedge clk) begin
    palette_write_t want;
    if (!rst_n) begin
      countdown_q = '0;
      start_q     = '0;
      count_q     = COUNT_W'(1);
      reverse_q   = 1'b0;
      delay_q     = '0;
      palette_writes_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (palette_writes_due.size() == 0) begin
          report_mismatch("palette write with none due, index", out_ch.palette_index, -1);
        end else begin
          want = palette_writes_due.pop_front();
          if (out_ch.palette_index !== want.index)
            report_mismatch("palette_index", out_ch.palette_index, want.index);
          if (out_ch.color_out !== want.color)
            report_mismatch("color_out", out_ch.color_out, want.color);
          if (out_ch.last !== want.last)
            report_mismatch("last", out_ch.last, want.last);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) write_register(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        advance_palette(in_ch.action, in_ch.slot, in_ch.color_word, in_ch.elapsed);
    end
    writes_due <= palette_writes_due.size();
  end

endmodule

>>> tb/sv/palette_color_cycler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_color_cycler_tb
// Drives load and tick items and register writes into the color cycler with
// random idle gaps on both sides, including one long receiver hold-off, and
// reports the verdict from the failure count of the palette write checker.
// ----------------------------------------------------------------------------
module palette_color_cycler_tb import pcc_pkg::*; ;

  localparam int MAX_COLORS    = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 12;

  logic clk;
  logic rst_n;

  pcc_in_if  in_if();
  pcc_out_if out_if();
  pcc_cfg_if cfg_if();

  int unsigned fail_count;
  int unsigned writes_due;
  bit          no_idle;
  bit          hold_req;

  palette_color_cycler #(.MAX_COLORS(MAX_COLORS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  palette_write_checker #(.MAX_COLORS(MAX_COLORS)) write_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_ch     (cfg_if),
    .fail_count (fail_count),
    .writes_due (writes_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int gap_cycles();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // small steps let the countdown expire often
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return ELAPSED_W'($urandom_range(0, 8));
      default: return ELAPSED_W'($urandom);
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = gap_cycles();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic act, input logic [SLOT_W-1:0] slot,
                           input logic [COLOR_W-1:0] word,
                           input logic [ELAPSED_W-1:0] elapsed);
    int n;
    n = gap_cycles();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.slot       <= slot;
    in_if.color_word <= word;
    in_if.elapsed    <= elapsed;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed);
    send_item(ACT_TICK, SLOT_W'($urandom), COLOR_W'($urandom), elapsed);
  endtask

  task automatic write_reg(input pcc_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] start, input logic [CFG_DATA_W-1:0] count,
                           input logic [CFG_DATA_W-1:0] rev, input logic [CFG_DATA_W-1:0] dly);
    write_reg(REG_START, start);
    write_reg(REG_COUNT, count);
    write_reg(REG_REVERSE, rev);
    write_reg(REG_DELAY, dly);
  endtask

  // wait for every due palette write, then let the block go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (writes_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int p);
    logic [CFG_DATA_W-1:0] cnt;
    case (p)
      0: configure(16'hFFC5, 16'h001F, 16'h0001, 16'h0000);
      1: configure(16'h003F, 16'h0020, 16'hFFFF, 16'h0002);
      6: configure(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      default: begin
        cnt = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(17, 31))
                                          : CFG_DATA_W'($urandom_range(1, 16));
        configure(CFG_DATA_W'($urandom), cnt, CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom_range(0, 40)));
      end
    endcase
    no_idle = (p == 3);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 9) < 3)
        send_item(ACT_LOAD, SLOT_W'($urandom_range(0, 15)), pick_color(), ELAPSED_W'($urandom));
      else
        send_tick(pick_elapsed());
    end
    settle();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.action     <= ACT_LOAD;
    in_if.slot       <= '0;
    in_if.color_word <= '0;
    in_if.elapsed    <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_START;
    cfg_if.data      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole ring, then fire with a count of one
    for (int s = 0; s < 16; s++) begin
      send_item(ACT_LOAD, SLOT_W'(s),
                (s == 0) ? COLOR_W'(0) : (s == 15) ? '1 : COLOR_W'($urandom),
                ELAPSED_W'($urandom));
    end
    send_tick(8'd0);
    send_tick(8'd255);
    settle();

    // palette index wraps past 63, countdown goes deep negative
    configure(16'd63, 16'd16, 16'd0, 16'd3);
    send_tick(8'd0);
    send_tick(8'd255);
    send_tick(8'd0);
    send_tick(8'd1);
    send_tick(8'd2);
    send_tick(8'd0);
    settle();

    for (int p = 0; p < PHASES - 1; p++) run_phase(p);

    // long receiver hold-off while firing ticks keep coming
    configure(CFG_DATA_W'($urandom_range(0, 63)), 16'd16, CFG_DATA_W'($urandom), 16'd0);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_tick(pick_elapsed());
    settle();
    no_idle = 1'b0;

    run_phase(PHASES - 1);

    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> palette_color_cycler.f
design/pcc_pkg.sv
design/pcc_in_if.sv
design/pcc_out_if.sv
design/pcc_cfg_if.sv
design/pcc_ctrl.sv
design/pcc_dpath.sv
design/palette_color_cycler.sv
design/pcc_checker.sv
tb/sv/palette_write_checker.sv
tb/sv/palette_color_cycler_tb.sv
